/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file of the trie dictionary block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TWIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TWIS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/twis_pkg.sv */
// Package with the shared constants, types and states of the trie dictionary block.
package twis_pkg;

  localparam int NODES_DEF    = 1024;
  localparam int ALPHABET_DEF = 26;
  localparam int LETTER_W     = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MARK,
    ST_EMIT
  } state_t;

  // Control from the clearing sequencer to the memory write ports.
  typedef struct packed {
    logic active;
    logic mark_we;
  } clear_t;

endpackage

/* rtl/core/twis_if.sv */
// Interfaces for the letter input channel and the result output channel.
interface twis_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [twis_pkg::LETTER_W-1:0]  letter;
  logic                           last_letter;

  modport source(output valid, func, letter, last_letter, input ready);
  modport sink(input valid, func, letter, last_letter, output ready);
endinterface

interface twis_out_if;
  logic valid;
  logic ready;
  logic found;
  logic overflow;

  modport source(output valid, found, overflow, input ready);
  modport sink(input valid, found, overflow, output ready);
endinterface

/* rtl/core/twis_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
module twis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/twis_clear.sv */
// Clearing sequencer that sweeps the link and mark memories to zero after reset.
module twis_clear #(
  parameter int NODES = twis_pkg::NODES_DEF,
  parameter int TOTAL = twis_pkg::NODES_DEF * twis_pkg::ALPHABET_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  output twis_pkg::clear_t         ctl,
  output logic [$clog2(TOTAL)-1:0] addr
);

  localparam int AW = $clog2(TOTAL);

  logic          active;
  logic [AW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b1;
      count  <= '0;
    end else if (active) begin
      if (count == AW'(TOTAL - 1)) begin
        active <= 1'b0;
      end else begin
        count <= count + AW'(1);
      end
    end
  end

  // The mark memory is shallower, so only the low part of the sweep writes it.
  assign ctl.active  = active;
  assign ctl.mark_we = active && (count < AW'(NODES));
  assign addr        = count;

endmodule

/* rtl/core/trie_word_insert_search.sv */
// Top level of the trie dictionary block: letter walk, node allocation and word marks.
//
//   Channel   Dir   Payload                       Beat
//   letters   in    func, letter, last_letter     one letter of a word
//   results   out   found, overflow               one answer per last letter
//
// A letter is accepted while its child link is read; the next cycle decides, allocates
// and writes back. A final insert letter answers in that cycle; a final search letter goes on
// to read the word-end mark it reached. After reset a clearing pass over all NODES*ALPHABET
// link slots (26624 at the default size) zeroes both memories, and no letter is accepted
// until it has finished. A waiting result only stalls the letters once a second result is
// ready and the output register is still full.
module trie_word_insert_search #(
  parameter int NODES    = twis_pkg::NODES_DEF,
  parameter int ALPHABET = twis_pkg::ALPHABET_DEF
) (
  input logic         clk,
  input logic         rst,
  twis_in_if.sink     letters,
  twis_out_if.source  results
);

  localparam int NW    = $clog2(NODES);
  localparam int TOTAL = NODES * ALPHABET;
  localparam int AW    = $clog2(TOTAL);

  twis_pkg::state_t state, state_next;

  // Walk state.
  logic [NW-1:0] cur_node;
  logic [NW:0]   free_node;
  logic          broken;
  logic          word_ovf;

  // The letter being worked on.
  logic          it_func;
  logic          it_last;
  logic          it_bad;
  logic [AW-1:0] it_slot;

  // Result waiting for the output register.
  logic res_broken;
  logic res_found;
  logic res_ovf;

  logic out_valid;
  logic out_found;
  logic out_ovf;

  // Clearing sequencer.
  twis_pkg::clear_t clr;
  logic [AW-1:0]    clr_addr;

  // Memory ports.
  logic [NW-1:0] link_q;
  logic          mark_q;
  logic          link_we;
  logic [AW-1:0] link_waddr;
  logic [NW-1:0] link_wdata;
  logic          mark_we;
  logic [NW-1:0] mark_waddr;

  // Decision logic.
  logic          accept;
  logic          out_free;
  logic [AW-1:0] slot_calc;
  logic          letter_bad;
  logic [NW-1:0] node_new;
  logic          brk_new;
  logic          ovf_new;
  logic          alloc;
  logic          mark_set;
  logic          mark_rd;
  logic          load_out;
  logic          load_found;
  logic          load_ovf;
  logic          save_res;
  logic          save_found;
  logic          save_ovf;

  assign accept   = letters.valid && letters.ready;
  assign out_free = !out_valid || results.ready;

  // Link slot of the current node for the incoming letter.
  assign slot_calc  = AW'(cur_node) * AW'(ALPHABET) + AW'(letters.letter);
  assign letter_bad = (32'(letters.letter) >= 32'(ALPHABET));

  twis_clear #(
    .NODES (NODES),
    .TOTAL (TOTAL)
  ) u_clear (
    .clk  (clk),
    .rst  (rst),
    .ctl  (clr),
    .addr (clr_addr)
  );

  // During the clearing pass the sweep owns both write ports.
  assign link_we    = clr.active || alloc;
  assign link_waddr = clr.active ? clr_addr : it_slot;
  assign link_wdata = clr.active ? '0 : free_node[NW-1:0];
  assign mark_we    = clr.mark_we || mark_set;
  assign mark_waddr = clr.active ? clr_addr[NW-1:0] : node_new;

  twis_ram #(
    .WIDTH (NW),
    .DEPTH (TOTAL)
  ) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (accept),
    .raddr (slot_calc),
    .rdata (link_q)
  );

  twis_ram #(
    .WIDTH (1),
    .DEPTH (NODES)
  ) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (!clr.active),
    .re    (mark_rd),
    .raddr (node_new),
    .rdata (mark_q)
  );

  // Where the walk goes with the link just read. A broken walk stays put, an
  // out-of-range letter breaks it, a missing child breaks a search, and an
  // insert takes a fresh node unless the pool is used up.
  always_comb begin
    node_new = cur_node;
    brk_new  = broken;
    ovf_new  = word_ovf;
    alloc    = 1'b0;
    if (state == twis_pkg::ST_LOOK && !broken) begin
      if (it_bad) begin
        brk_new = 1'b1;
      end else if (link_q != '0) begin
        node_new = link_q;
      end else if (!it_func) begin
        brk_new = 1'b1;
      end else if (free_node < (NW + 1)'(NODES)) begin
        alloc    = 1'b1;
        node_new = free_node[NW-1:0];
      end else begin
        brk_new = 1'b1;
        ovf_new = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      twis_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = twis_pkg::ST_LOOK;
        end
      end
      twis_pkg::ST_LOOK: begin
        if (!it_last) begin
          state_next = twis_pkg::ST_IDLE;
        end else if (!it_func) begin
          state_next = twis_pkg::ST_MARK;
        end else if (out_free) begin
          state_next = twis_pkg::ST_IDLE;
        end else begin
          state_next = twis_pkg::ST_EMIT;
        end
      end
      twis_pkg::ST_MARK: begin
        state_next = out_free ? twis_pkg::ST_IDLE : twis_pkg::ST_EMIT;
      end
      twis_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = twis_pkg::ST_IDLE;
        end
      end
      default: state_next = twis_pkg::ST_IDLE;
    endcase
  end

  // Step outputs: mark writes, mark reads and result hand-over.
  always_comb begin
    letters.ready = 1'b0;
    mark_set      = 1'b0;
    mark_rd       = 1'b0;
    load_out      = 1'b0;
    load_found    = 1'b0;
    load_ovf      = 1'b0;
    save_res      = 1'b0;
    save_found    = 1'b0;
    save_ovf      = 1'b0;
    case (state)
      twis_pkg::ST_IDLE: begin
        letters.ready = !clr.active;
      end
      twis_pkg::ST_LOOK: begin
        if (it_last && it_func) begin
          mark_set   = !brk_new;
          load_found = !brk_new;
          load_ovf   = ovf_new;
          save_found = !brk_new;
          save_ovf   = ovf_new;
          load_out   = out_free;
          save_res   = !out_free;
        end else if (it_last) begin
          mark_rd = 1'b1;
        end
      end
      twis_pkg::ST_MARK: begin
        load_found = !res_broken && mark_q;
        save_found = !res_broken && mark_q;
        load_out   = out_free;
        save_res   = !out_free;
      end
      twis_pkg::ST_EMIT: begin
        load_found = res_found;
        load_ovf   = res_ovf;
        load_out   = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= twis_pkg::ST_IDLE;
      cur_node  <= '0;
      free_node <= (NW + 1)'(1);
      broken    <= 1'b0;
      word_ovf  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (alloc) begin
        free_node <= free_node + (NW + 1)'(1);
      end
      // The walk returns to the root after every last letter.
      if (state == twis_pkg::ST_LOOK) begin
        cur_node <= it_last ? '0 : node_new;
        broken   <= it_last ? 1'b0 : brk_new;
        word_ovf <= it_last ? 1'b0 : ovf_new;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      it_func <= letters.func;
      it_last <= letters.last_letter;
      it_bad  <= letter_bad;
      it_slot <= slot_calc;
    end
    if (mark_rd) begin
      res_broken <= brk_new;
    end
    if (save_res) begin
      res_found <= save_found;
      res_ovf   <= save_ovf;
    end
    if (load_out) begin
      out_found <= load_found;
      out_ovf   <= load_ovf;
    end
  end

  assign results.valid    = out_valid;
  assign results.found    = out_found;
  assign results.overflow = out_ovf;

endmodule

/* rtl/core/twis_check.sv */
// Port-level checker for the trie dictionary block, bound to its top level.
`include "assert_macros.svh"

module twis_check (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_found,
  input logic out_overflow
);

  // A result beat waiting on the sink stays offered.
  `TWIS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")

  // A word that overflowed is never also reported as stored.
  `TWIS_ASSERT(a_ovf_excl, out_valid |-> !(out_found && out_overflow), "found and overflow both set")

  // Each letter is worked on before the next one is accepted.
  `TWIS_ASSERT(a_one_letter, in_valid && in_ready |=> !in_ready, "letter accepted back to back")

  // The clearing pass keeps the input closed right after reset.
  `TWIS_ASSERT_ALWAYS(a_clear_closed, $fell(rst) |-> !in_ready, "input open during clearing pass")

endmodule

bind trie_word_insert_search twis_check u_twis_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (letters.valid),
  .in_ready     (letters.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_found    (results.found),
  .out_overflow (results.overflow)
);
